>>> hdl/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Shared codes, widths and structs of the periodic task tick scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int SLOT_W = 6;
    localparam int TIME_W = 8;

    // command modes
    localparam logic [2:0] MODE_TICK    = 3'd0;
    localparam logic [2:0] MODE_CREATE  = 3'd1;
    localparam logic [2:0] MODE_DELETE  = 3'd2;
    localparam logic [2:0] MODE_SUSPEND = 3'd3;
    localparam logic [2:0] MODE_RESUME  = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_RANGE  = 2'd1;
    localparam logic [1:0] ST_USED   = 2'd2;
    localparam logic [1:0] ST_NOTASK = 2'd3;

    // most fired tasks reported on one tick
    localparam logic [4:0] REPORT_LIMIT = 5'd16;

    // update request from the sequencer to the task table
    typedef struct packed {
        logic                  set_present;
        logic                  clr_present;
        logic                  set_susp;
        logic                  clr_susp;
        logic [SLOT_W-1:0]     flag_slot;
        logic                  mem_we;
        logic [SLOT_W-1:0]     mem_slot;
        logic [2*TIME_W-1:0]   mem_data;   // {reload, countdown}
    } pts_tbl_wr_t;

    // one result item
    typedef struct packed {
        logic [1:0]        status;
        logic              fired;
        logic [SLOT_W-1:0] fired_slot;
        logic              last;
    } pts_result_t;

endpackage

>>> hdl/periodic_task_tick_scheduler.sv
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler
// Time-triggered cooperative scheduler over a table of periodic task slots.
// ----------------------------------------------------------------------------
// Command: accepted in S_IDLE, status result held in S_REPLY until the output
//   register takes it; the next item is accepted once back in S_IDLE.
// Tick: per slot a memory read (S_READ), then a countdown update (S_UPDATE);
//   S_FLUSH then sends the last result. Output stalls can hold the scan.
// Reset: flags and control cleared at once; countdown memory is not cleared,
//   the present flag guards it, so the block is ready right after reset.
module periodic_task_tick_scheduler
    import pts_pkg::*;
#(
    parameter int NUM_TASKS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  logic [2:0]        mode,
    input  logic [SLOT_W-1:0] slot,
    input  logic [TIME_W-1:0] period,
    input  logic [TIME_W-1:0] first_delay,
    output logic              res_valid,
    input  logic              res_ready,
    output logic [1:0]        status,
    output logic              fired,
    output logic [SLOT_W-1:0] fired_slot,
    output logic              last
);

    localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam logic [SLOT_W:0] NT = (SLOT_W+1)'(NUM_TASKS);

    pts_tbl_wr_t          wr;
    logic [IDX_W-1:0]     rd_addr;
    logic [2*TIME_W-1:0]  rd_data;
    logic [NUM_TASKS-1:0] present;
    logic [NUM_TASKS-1:0] suspended;
    logic                 emit;
    logic                 emit_ok;
    pts_result_t          result;
    logic                 res_valid_reg;
    pts_result_t          res_reg;

    pts_table #(
        .NUM_TASKS (NUM_TASKS),
        .IDX_W     (IDX_W)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .present   (present),
        .suspended (suspended)
    );

    pts_sequencer #(
        .NUM_TASKS (NUM_TASKS),
        .IDX_W     (IDX_W)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .mode        (mode),
        .slot        (slot),
        .period      (period),
        .first_delay (first_delay),
        .present     (present),
        .suspended   (suspended),
        .rd_data     (rd_data),
        .rd_addr     (rd_addr),
        .wr          (wr),
        .emit        (emit),
        .emit_ok     (emit_ok),
        .result      (result)
    );

    // output register, refilled in the cycle its transfer completes
    assign emit_ok = !res_valid_reg || res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (emit_ok)
            res_valid_reg <= emit;
    end

    always_ff @(posedge clk)
    begin
        if (emit && emit_ok)
            res_reg <= result;
    end

    assign res_valid  = res_valid_reg;
    assign status     = res_reg.status;
    assign fired      = res_reg.fired;
    assign fired_slot = res_reg.fired_slot;
    assign last       = res_reg.last;

    // a non-final tick result means the scan is still running
    a_busy_mid_tick: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !last |-> !cmd_ready)
        else $error("input ready while tick results still pending");

    // fire reports carry ok status and an existing slot
    a_fire_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && fired |-> (status == ST_OK) && ({1'b0, fired_slot} < NT))
        else $error("fire report with bad status or slot");

    // non-fire results are always final
    a_nofire_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !fired |-> last && (fired_slot == '0))
        else $error("non-fire result not marked last");

    // a waiting result is not overwritten
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_reg))
        else $error("stalled result changed");

endmodule

>>> hdl/pts_table.sv
// ----------------------------------------------------------------------------
// pts_table
// Task slot table: present and suspended flags in flops, reload and
// countdown in a one-write one-read memory with registered read data.
// ----------------------------------------------------------------------------
module pts_table
    import pts_pkg::*;
#(
    parameter int NUM_TASKS = 16,
    parameter int IDX_W     = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  pts_tbl_wr_t          wr,
    input  logic [IDX_W-1:0]     rd_addr,
    output logic [2*TIME_W-1:0]  rd_data,
    output logic [NUM_TASKS-1:0] present,
    output logic [NUM_TASKS-1:0] suspended
);

    logic [NUM_TASKS-1:0] present_reg;
    logic [NUM_TASKS-1:0] susp_reg;
    logic [2*TIME_W-1:0]  mem [NUM_TASKS];
    logic [2*TIME_W-1:0]  rd_data_reg;
    logic [IDX_W-1:0]     flag_idx;
    logic [IDX_W-1:0]     mem_idx;

    assign flag_idx = wr.flag_slot[IDX_W-1:0];
    assign mem_idx  = wr.mem_slot[IDX_W-1:0];

    // slot flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
            susp_reg    <= '0;
        end
        else
        begin
            if (wr.set_present)
                present_reg[flag_idx] <= 1'b1;
            else if (wr.clr_present)
                present_reg[flag_idx] <= 1'b0;
            if (wr.set_susp)
                susp_reg[flag_idx] <= 1'b1;
            else if (wr.clr_susp)
                susp_reg[flag_idx] <= 1'b0;
        end
    end

    // reload and countdown memory, guarded by the present flag
    always_ff @(posedge clk)
    begin
        if (wr.mem_we)
            mem[mem_idx] <= wr.mem_data;
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data   = rd_data_reg;
    assign present   = present_reg;
    assign suspended = susp_reg;

endmodule

>>> hdl/pts_sequencer.sv
// ----------------------------------------------------------------------------
// pts_sequencer
// Command decode and tick scan sequencer with the shared countdown unit;
// holds back each fired task until the next one shows whether it is last.
// ----------------------------------------------------------------------------
module pts_sequencer
    import pts_pkg::*;
#(
    parameter int NUM_TASKS = 16,
    parameter int IDX_W     = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  logic [2:0]           mode,
    input  logic [SLOT_W-1:0]    slot,
    input  logic [TIME_W-1:0]    period,
    input  logic [TIME_W-1:0]    first_delay,
    input  logic [NUM_TASKS-1:0] present,
    input  logic [NUM_TASKS-1:0] suspended,
    input  logic [2*TIME_W-1:0]  rd_data,
    output logic [IDX_W-1:0]     rd_addr,
    output pts_tbl_wr_t          wr,
    output logic                 emit,
    input  logic                 emit_ok,
    output pts_result_t          result
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_READ   = 5'b00010,
        S_UPDATE = 5'b00100,
        S_FLUSH  = 5'b01000,
        S_REPLY  = 5'b10000
    } state_t;

    localparam logic [SLOT_W:0] NT       = (SLOT_W+1)'(NUM_TASKS);
    localparam logic [IDX_W-1:0] IDX_END = IDX_W'(NUM_TASKS - 1);

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [4:0]        n_reg, n_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [SLOT_W-1:0] pend_slot_reg, pend_slot_next;
    logic [1:0]        status_reg, status_next;

    logic              accept;
    logic              in_range;
    logic [IDX_W-1:0]  cmd_idx;
    logic              cmd_present;
    logic [1:0]        cmd_status;
    logic              cmd_act;
    logic [TIME_W-1:0] cd;
    logic [TIME_W-1:0] rl;
    logic              cd_zero;
    logic [TIME_W-1:0] cd_dec;
    logic              active;
    logic              report;
    logic              stall;

    assign accept      = cmd_valid && cmd_ready;
    assign in_range    = {1'b0, slot} < NT;
    assign cmd_idx     = slot[IDX_W-1:0];
    assign cmd_present = in_range && present[cmd_idx];

    // command status
    always_comb
    begin
        cmd_act    = 1'b0;
        cmd_status = ST_OK;
        case (mode)
            MODE_CREATE:
            begin
                if (!in_range)
                    cmd_status = ST_RANGE;
                else if (cmd_present)
                    cmd_status = ST_USED;
                else
                    cmd_act = 1'b1;
            end
            MODE_DELETE, MODE_SUSPEND, MODE_RESUME:
            begin
                if (!in_range)
                    cmd_status = ST_RANGE;
                else if (!cmd_present)
                    cmd_status = ST_NOTASK;
                else
                    cmd_act = 1'b1;
            end
            default:
                cmd_status = ST_OK;
        endcase
    end

    // shared countdown unit: zero test and decrement
    assign rl      = rd_data[2*TIME_W-1:TIME_W];
    assign cd      = rd_data[TIME_W-1:0];
    assign cd_zero = (cd == '0);
    assign cd_dec  = cd - TIME_W'(1);

    assign active = present[idx_reg] && !suspended[idx_reg];
    assign report = active && cd_zero && (n_reg < REPORT_LIMIT);
    assign stall  = report && pend_valid_reg && !emit_ok;

    assign cmd_ready = (state_reg == S_IDLE);
    assign rd_addr   = idx_reg;

    // next state, table writes and results
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        status_next     = status_reg;
        wr              = '0;
        emit            = 1'b0;
        result          = '0;
        result.last     = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (mode == MODE_TICK)
                    begin
                        idx_next        = '0;
                        n_next          = '0;
                        pend_valid_next = 1'b0;
                        state_next      = S_READ;
                    end
                    else
                    begin
                        status_next  = cmd_status;
                        wr.flag_slot = slot;
                        wr.mem_slot  = slot;
                        wr.mem_data  = {period, first_delay};
                        if (cmd_act)
                        begin
                            case (mode)
                                MODE_CREATE:
                                begin
                                    wr.set_present = 1'b1;
                                    wr.clr_susp    = 1'b1;
                                    wr.mem_we      = 1'b1;
                                end
                                MODE_DELETE:
                                begin
                                    wr.clr_present = 1'b1;
                                    wr.clr_susp    = 1'b1;
                                end
                                MODE_SUSPEND:
                                    wr.set_susp = 1'b1;
                                default:
                                    wr.clr_susp = 1'b1;
                            endcase
                        end
                        state_next = S_REPLY;
                    end
                end
            end
            S_READ:
                state_next = S_UPDATE;
            S_UPDATE:
            begin
                // send the held fire on ahead when a newer one replaces it
                if (report && pend_valid_reg)
                begin
                    emit              = 1'b1;
                    result.fired      = 1'b1;
                    result.fired_slot = pend_slot_reg;
                    result.last       = 1'b0;
                end
                if (!stall)
                begin
                    wr.mem_slot = SLOT_W'(idx_reg);
                    wr.mem_data = cd_zero ? {rl, rl} : {rl, cd_dec};
                    wr.mem_we   = active;
                    if (report)
                    begin
                        pend_valid_next = 1'b1;
                        pend_slot_next  = SLOT_W'(idx_reg);
                        n_next          = n_reg + 5'd1;
                    end
                    if (idx_reg == IDX_END)
                        state_next = S_FLUSH;
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_READ;
                    end
                end
            end
            S_FLUSH:
            begin
                emit              = 1'b1;
                result.fired      = pend_valid_reg;
                result.fired_slot = pend_valid_reg ? pend_slot_reg : '0;
                if (emit_ok)
                    state_next = S_IDLE;
            end
            S_REPLY:
            begin
                emit          = 1'b1;
                result.status = status_reg;
                if (emit_ok)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_slot_reg <= pend_slot_next;
        status_reg    <= status_next;
    end

endmodule

>>> tb/sv/tb_periodic_task_tick_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_task_tick_scheduler
// Self-checking bench for the periodic task tick scheduler. A scoreboard
// keeps its own copy of the task table, predicts the status and fire
// results of every command and tick it sees go in, and compares them in
// order with the results coming out. Directed corner cases first, then
// random command mixes with full-table sweeps and random back-pressure.
// ----------------------------------------------------------------------------
module tb_periodic_task_tick_scheduler;

    import pts_pkg::*;

    localparam int NUM_TASKS       = 16;
    localparam int RANDOM_ITEMS    = 300;
    localparam int CALM_ITEMS      = 60;
    localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [2:0] MODE_SPARE_MID   = 3'd6;
    localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

    // task table shadow plus queue of results still owed by the block
    class sched_scoreboard;
        bit                task_present [NUM_TASKS];
        bit                task_susp    [NUM_TASKS];
        logic [TIME_W-1:0] task_reload  [NUM_TASKS];
        logic [TIME_W-1:0] task_count   [NUM_TASKS];
        pts_result_t       due_results  [$];
        int                mismatches = 0;

        function void push_result(logic [1:0] st, logic f, logic [SLOT_W-1:0] s, logic l);
            pts_result_t r;
            r.status     = st;
            r.fired      = f;
            r.fired_slot = s;
            r.last       = l;
            due_results.push_back(r);
        endfunction

        function logic [1:0] apply_command(logic [2:0] m, int idx, logic [TIME_W-1:0] per,
                                           logic [TIME_W-1:0] fd);
            if (idx >= NUM_TASKS)
                return ST_RANGE;
            if (m == MODE_CREATE)
            begin
                if (task_present[idx])
                    return ST_USED;
                task_present[idx] = 1'b1;
                task_susp[idx]    = 1'b0;
                task_reload[idx]  = per;
                task_count[idx]   = fd;
                return ST_OK;
            end
            if (!task_present[idx])
                return ST_NOTASK;
            case (m)
                MODE_DELETE:
                begin
                    task_present[idx] = 1'b0;
                    task_susp[idx]    = 1'b0;
                    task_reload[idx]  = '0;
                    task_count[idx]   = '0;
                end
                MODE_SUSPEND: task_susp[idx] = 1'b1;
                default:      task_susp[idx] = 1'b0;
            endcase
            return ST_OK;
        endfunction

        // accepted input transfer: update the table and queue its results
        function void note_command(logic [2:0] m, logic [SLOT_W-1:0] s,
                                   logic [TIME_W-1:0] per, logic [TIME_W-1:0] fd);
            int          n;
            pts_result_t r;
            n = 0;
            if (m == MODE_TICK)
            begin
                for (int i = 0; i < NUM_TASKS; i++)
                begin
                    if (task_present[i] && !task_susp[i])
                    begin
                        if (task_count[i] == '0)
                        begin
                            task_count[i] = task_reload[i];
                            if (n < REPORT_LIMIT)
                            begin
                                push_result(ST_OK, 1'b1, SLOT_W'(i), 1'b0);
                                n++;
                            end
                        end
                        else
                        begin
                            task_count[i] = task_count[i] - 1'b1;
                        end
                    end
                end
                if (n == 0)
                begin
                    push_result(ST_OK, 1'b0, '0, 1'b1);
                end
                else
                begin
                    r = due_results.pop_back();
                    r.last = 1'b1;
                    due_results.push_back(r);
                end
            end
            else if (m > MODE_RESUME)
            begin
                push_result(ST_OK, 1'b0, '0, 1'b1);
            end
            else
            begin
                push_result(apply_command(m, int'(s), per, fd), 1'b0, '0, 1'b1);
            end
        endfunction

        function void compare_field(string name, int exp_v, int act_v);
            if (exp_v != act_v)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_v, act_v);
                mismatches++;
            end
        endfunction

        // accepted result transfer: compare with the oldest prediction
        function void check_result(pts_result_t got);
            pts_result_t want;
            if (due_results.size() == 0)
            begin
                $display({"%0t: unexpected result, expected none, ",
                          "actual status %0d fired %0d slot %0d last %0d"},
                         $time, got.status, got.fired, got.fired_slot, got.last);
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("fired", want.fired, got.fired);
            compare_field("fired_slot", want.fired_slot, got.fired_slot);
            compare_field("last", want.last, got.last);
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cmd_valid;
    logic              cmd_ready;
    logic [2:0]        mode;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] first_delay;
    logic              res_valid;
    logic              res_ready;
    logic [1:0]        status;
    logic              fired;
    logic [SLOT_W-1:0] fired_slot;
    logic              last;

    // no idling on either side near the end of the run
    bit              calm;
    sched_scoreboard sb;

    periodic_task_tick_scheduler #(
        .NUM_TASKS  (NUM_TASKS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .mode        (mode),
        .slot        (slot),
        .period      (period),
        .first_delay (first_delay),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .status      (status),
        .fired       (fired),
        .fired_slot  (fired_slot),
        .last        (last)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #15_000_000;
        $display("tb_periodic_task_tick_scheduler NOT OK");
        $finish;
    end

    // sample both channels at the rising edge
    always @(posedge clk)
    begin : monitor
        pts_result_t seen;
        if (rst_n)
        begin
            if (cmd_valid && cmd_ready)
                sb.note_command(mode, slot, period, first_delay);
            if (res_valid && res_ready)
            begin
                seen.status     = status;
                seen.fired      = fired;
                seen.fired_slot = fired_slot;
                seen.last       = last;
                sb.check_result(seen);
            end
        end
    end

    // result side back-pressure in random bursts
    initial
    begin
        res_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            res_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(negedge clk);
            if (!calm && $urandom_range(0, 1) == 1)
            begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end
        end
    end

    // one command transfer, called and returning at a falling edge
    task automatic send_item(input logic [2:0] m, input logic [SLOT_W-1:0] s,
                             input logic [TIME_W-1:0] per, input logic [TIME_W-1:0] fd);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        cmd_valid   <= 1'b1;
        mode        <= m;
        slot        <= s;
        period      <= per;
        first_delay <= fd;
        do
            @(posedge clk);
        while (!cmd_ready);
        @(negedge clk);
    endtask

    // rebuild the whole table so that every slot fires together
    task automatic sweep_table(input logic [TIME_W-1:0] per);
        for (int i = 0; i < NUM_TASKS; i++)
            send_item(MODE_DELETE, SLOT_W'(i), 8'($urandom), 8'($urandom));
        for (int i = 0; i < NUM_TASKS; i++)
            send_item(MODE_CREATE, SLOT_W'(i), per, '0);
        repeat (4)
            send_item(MODE_TICK, 6'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // random item, mostly well-formed commands on real slots
    task automatic random_item();
        int                pick;
        logic [2:0]        m;
        logic [SLOT_W-1:0] s;
        logic [TIME_W-1:0] per;
        logic [TIME_W-1:0] fd;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            m = MODE_TICK;
        else if (pick < 62)
            m = MODE_CREATE;
        else if (pick < 74)
            m = MODE_DELETE;
        else if (pick < 84)
            m = MODE_SUSPEND;
        else if (pick < 94)
            m = MODE_RESUME;
        else
            m = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
        if ($urandom_range(0, 9) == 0)
            s = SLOT_W'($urandom_range(NUM_TASKS, 63));
        else
            s = SLOT_W'($urandom_range(0, NUM_TASKS - 1));
        per = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
        fd  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
        send_item(m, s, per, fd);
    endtask

    // reset, stimulus and end of run
    initial
    begin
        sb          = new();
        calm        = 1'b0;
        rst_n       = 1'b0;
        cmd_valid   = 1'b0;
        mode        = MODE_TICK;
        slot        = '0;
        period      = '0;
        first_delay = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty table, then corner values and every error status
        send_item(MODE_TICK,    6'd0,  8'd0,   8'd0);
        send_item(MODE_CREATE,  6'd0,  8'd0,   8'd0);
        send_item(MODE_CREATE,  6'd15, 8'd255, 8'd255);
        send_item(MODE_CREATE,  6'd7,  8'd3,   8'd1);
        send_item(MODE_CREATE,  6'd0,  8'd9,   8'd9);
        send_item(MODE_CREATE,  6'd16, 8'd1,   8'd1);
        send_item(MODE_CREATE,  6'd63, 8'd255, 8'd255);
        send_item(MODE_DELETE,  6'd63, 8'd0,   8'd0);
        send_item(MODE_SUSPEND, 6'd32, 8'd0,   8'd0);
        send_item(MODE_RESUME,  6'd16, 8'd0,   8'd0);
        send_item(MODE_DELETE,  6'd5,  8'd0,   8'd0);
        send_item(MODE_SUSPEND, 6'd5,  8'd0,   8'd0);
        send_item(MODE_RESUME,  6'd5,  8'd0,   8'd0);
        send_item(MODE_TICK,    6'd0,  8'd0,   8'd0);
        send_item(MODE_TICK,    6'd63, 8'd255, 8'd255);
        // suspended slot skips ticks and keeps its countdown
        send_item(MODE_SUSPEND, 6'd0,  8'd0,   8'd0);
        send_item(MODE_TICK,    6'd0,  8'd0,   8'd0);
        send_item(MODE_RESUME,  6'd0,  8'd0,   8'd0);
        send_item(MODE_TICK,    6'd0,  8'd0,   8'd0);
        // delete clears the slot so it can be created again
        send_item(MODE_DELETE,  6'd15, 8'd0,   8'd0);
        send_item(MODE_CREATE,  6'd15, 8'd0,   8'd0);
        send_item(MODE_TICK,    6'd0,  8'd0,   8'd0);
        // unused modes
        send_item(MODE_SPARE_FIRST,  6'd63, 8'd255, 8'd255);
        send_item(MODE_SPARE_MID,    6'd1,  8'd1,   8'd0);
        send_item(MODE_SPARE_LAST,   6'd42, 8'd170, 8'd85);

        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            calm = (k >= RANDOM_ITEMS - CALM_ITEMS);
            if (k == 100)
                sweep_table(8'd0);
            if (k == 200)
                sweep_table(8'd1);
            random_item();
        end
        cmd_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4 * NUM_TASKS) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb_periodic_task_tick_scheduler OK");
        else
            $display("tb_periodic_task_tick_scheduler NOT OK");
        $finish;
    end

endmodule
